@@ rtl/wpe_pkg.sv @@
package wpe_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int HALF_WIDTH = SAMPLE_WIDTH - 1;
  localparam int CHANNELS_MAX = 8;
  localparam int BUCKETS_MAX = 4096;
  localparam int FRAMES_PER_BUCKET_MAX = 65535;

  localparam int CHANNEL_COUNT_WIDTH = 4;
  localparam int SELECTED_CHANNEL_WIDTH = 3;
  localparam int FRAMES_WIDTH = 16;
  localparam int BUCKET_COUNT_WIDTH = 13;
  localparam int BUCKET_INDEX_WIDTH = 12;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 16;

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MOST_POS =
    {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MOST_NEG =
    {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_CHANNEL_COUNT     = 3'd0,
    CFG_SELECTED_CHANNEL  = 3'd1,
    CFG_FRAMES_PER_BUCKET = 3'd2,
    CFG_BUCKET_COUNT      = 3'd3
  } cfg_index_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           start_of_pass;
  } sample_item_t;

  typedef struct packed {
    logic [HALF_WIDTH-1:0]         half_span;
    logic [BUCKET_INDEX_WIDTH-1:0] bucket_index;
    logic                          last_bucket;
  } result_item_t;

endpackage

@@ rtl/wpe_in_reg.sv @@
module wpe_in_reg import wpe_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         sample_valid,
  output logic         sample_ready,
  input  sample_item_t sample_item,
  output logic         held_valid,
  output sample_item_t held_item,
  input  logic         pop
);

  assign sample_ready = !held_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (sample_ready) begin
      held_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      held_item <= sample_item;
    end
  end

endmodule

@@ rtl/wpe_core.sv @@
module wpe_core import wpe_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       held_valid,
  input  sample_item_t               held_item,
  input  logic                       step,
  output logic                       emit,
  output result_item_t               result
);

  logic [CHANNEL_COUNT_WIDTH-1:0]    channel_count;
  logic [SELECTED_CHANNEL_WIDTH-1:0] selected_channel;
  logic [FRAMES_WIDTH-1:0]           frames_per_bucket;
  logic [BUCKET_COUNT_WIDTH-1:0]     bucket_count;

  logic [SELECTED_CHANNEL_WIDTH-1:0] channel_position;
  logic [FRAMES_WIDTH-1:0]           frame_in_bucket;
  logic [BUCKET_INDEX_WIDTH-1:0]     bucket_number;
  logic signed [SAMPLE_WIDTH-1:0]    running_min;
  logic signed [SAMPLE_WIDTH-1:0]    running_max;
  logic                              pass_done;

  logic [SELECTED_CHANNEL_WIDTH-1:0] channel_position_next;
  logic [FRAMES_WIDTH-1:0]           frame_in_bucket_next;
  logic [BUCKET_INDEX_WIDTH-1:0]     bucket_number_next;
  logic signed [SAMPLE_WIDTH-1:0]    running_min_next;
  logic signed [SAMPLE_WIDTH-1:0]    running_max_next;
  logic                              pass_done_next;

  logic [CHANNEL_COUNT_WIDTH-1:0]    cc;
  logic [FRAMES_WIDTH-1:0]           fpb;
  logic [BUCKET_COUNT_WIDTH-1:0]     nb;
  logic                              channel_ok;

  logic [SELECTED_CHANNEL_WIDTH-1:0] eff_pos;
  logic [FRAMES_WIDTH-1:0]           eff_frame;
  logic [BUCKET_INDEX_WIDTH-1:0]     eff_bucket;
  logic signed [SAMPLE_WIDTH-1:0]    eff_min;
  logic signed [SAMPLE_WIDTH-1:0]    eff_max;
  logic                              eff_done;

  logic                              take;
  logic signed [SAMPLE_WIDTH-1:0]    min_upd;
  logic signed [SAMPLE_WIDTH-1:0]    max_upd;
  logic [SAMPLE_WIDTH:0]             diff;
  logic                              frame_end;
  logic                              bucket_end;
  logic                              last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count     <= CHANNEL_COUNT_WIDTH'(1);
      selected_channel  <= '0;
      frames_per_bucket <= FRAMES_WIDTH'(1);
      bucket_count      <= BUCKET_COUNT_WIDTH'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CHANNEL_COUNT: begin
          channel_count <= cfg_data[CHANNEL_COUNT_WIDTH-1:0];
        end
        CFG_SELECTED_CHANNEL: begin
          selected_channel <= cfg_data[SELECTED_CHANNEL_WIDTH-1:0];
        end
        CFG_FRAMES_PER_BUCKET: begin
          frames_per_bucket <= cfg_data[FRAMES_WIDTH-1:0];
        end
        CFG_BUCKET_COUNT: begin
          bucket_count <= cfg_data[BUCKET_COUNT_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // effective register values
  always_comb begin
    if (channel_count == '0) begin
      cc = CHANNEL_COUNT_WIDTH'(1);
    end else if (channel_count > CHANNEL_COUNT_WIDTH'(CHANNELS_MAX)) begin
      cc = CHANNEL_COUNT_WIDTH'(CHANNELS_MAX);
    end else begin
      cc = channel_count;
    end
    if (frames_per_bucket == '0) begin
      fpb = FRAMES_WIDTH'(1);
    end else if (frames_per_bucket > FRAMES_WIDTH'(FRAMES_PER_BUCKET_MAX)) begin
      fpb = FRAMES_WIDTH'(FRAMES_PER_BUCKET_MAX);
    end else begin
      fpb = frames_per_bucket;
    end
    if (bucket_count == '0) begin
      nb = BUCKET_COUNT_WIDTH'(1);
    end else if (bucket_count > BUCKET_COUNT_WIDTH'(BUCKETS_MAX)) begin
      nb = BUCKET_COUNT_WIDTH'(BUCKETS_MAX);
    end else begin
      nb = bucket_count;
    end
  end

  assign channel_ok = CHANNEL_COUNT_WIDTH'(selected_channel) < cc;

  // start of pass restarts everything before the sample is used
  always_comb begin
    if (held_item.start_of_pass) begin
      eff_pos    = '0;
      eff_frame  = '0;
      eff_bucket = '0;
      eff_min    = SAMPLE_MOST_POS;
      eff_max    = SAMPLE_MOST_NEG;
      eff_done   = 1'b0;
    end else begin
      eff_pos    = channel_position;
      eff_frame  = frame_in_bucket;
      eff_bucket = bucket_number;
      eff_min    = running_min;
      eff_max    = running_max;
      eff_done   = pass_done;
    end
  end

  assign take    = channel_ok && (eff_pos == selected_channel);
  assign min_upd = (take && (held_item.sample < eff_min)) ? held_item.sample : eff_min;
  assign max_upd = (take && (held_item.sample > eff_max)) ? held_item.sample : eff_max;
  assign diff    = {max_upd[SAMPLE_WIDTH-1], max_upd} - {min_upd[SAMPLE_WIDTH-1], min_upd};

  assign frame_end  = (CHANNEL_COUNT_WIDTH'(eff_pos) + CHANNEL_COUNT_WIDTH'(1)) >= cc;
  assign bucket_end = frame_end &&
                      ((FRAMES_WIDTH+1)'(eff_frame) + (FRAMES_WIDTH+1)'(1)
                       >= (FRAMES_WIDTH+1)'(fpb));
  assign last       = (BUCKET_COUNT_WIDTH'(eff_bucket) + BUCKET_COUNT_WIDTH'(1)) >= nb;
  assign emit       = held_valid && !eff_done && bucket_end;

  always_comb begin
    result.half_span    = (channel_ok && (max_upd >= min_upd)) ?
                          diff[SAMPLE_WIDTH-1:1] : '0;
    result.bucket_index = eff_bucket;
    result.last_bucket  = last;
  end

  always_comb begin
    channel_position_next = eff_pos;
    frame_in_bucket_next  = eff_frame;
    bucket_number_next    = eff_bucket;
    running_min_next      = eff_min;
    running_max_next      = eff_max;
    pass_done_next        = eff_done;
    if (!eff_done) begin
      running_min_next = min_upd;
      running_max_next = max_upd;
      if (!frame_end) begin
        channel_position_next = eff_pos + SELECTED_CHANNEL_WIDTH'(1);
      end else begin
        channel_position_next = '0;
        if (!bucket_end) begin
          frame_in_bucket_next = eff_frame + FRAMES_WIDTH'(1);
        end else begin
          frame_in_bucket_next = '0;
          running_min_next     = SAMPLE_MOST_POS;
          running_max_next     = SAMPLE_MOST_NEG;
          if (last) begin
            pass_done_next = 1'b1;
          end else begin
            bucket_number_next = eff_bucket + BUCKET_INDEX_WIDTH'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_position <= '0;
      frame_in_bucket  <= '0;
      bucket_number    <= '0;
      running_min      <= SAMPLE_MOST_POS;
      running_max      <= SAMPLE_MOST_NEG;
      pass_done        <= 1'b0;
    end else if (step) begin
      channel_position <= channel_position_next;
      frame_in_bucket  <= frame_in_bucket_next;
      bucket_number    <= bucket_number_next;
      running_min      <= running_min_next;
      running_max      <= running_max_next;
      pass_done        <= pass_done_next;
    end
  end

`ifndef SYNTH
  a_done_counters_idle: assert property (@(posedge clk) disable iff (rst)
    pass_done |-> (frame_in_bucket == '0) && (channel_position == '0))
    else $error("pass done with counters not cleared");

  a_last_sets_done: assert property (@(posedge clk) disable iff (rst)
    (step && emit && result.last_bucket) |=> pass_done)
    else $error("last bucket did not end the pass");

  a_bucket_advance: assert property (@(posedge clk) disable iff (rst)
    (step && emit && !result.last_bucket) |=>
      (bucket_number == BUCKET_INDEX_WIDTH'($past(result.bucket_index) + 1'b1)))
    else $error("bucket number did not advance");

  a_bad_channel_zero: assert property (@(posedge clk) disable iff (rst)
    (emit && !channel_ok) |-> (result.half_span == '0))
    else $error("nonzero span for channel out of range");
`endif

endmodule

@@ rtl/wpe_out_reg.sv @@
module wpe_out_reg import wpe_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  result_item_t load_item,
  output logic         free,
  output logic         result_valid,
  input  logic         result_ready,
  output result_item_t result_item
);

  assign free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (free) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      result_item <= load_item;
    end
  end

endmodule

@@ rtl/waveform_peak_envelope_top.sv @@
// channel   handshake                   payload
// sample    sample_valid/sample_ready   sample_item (sample, start_of_pass)
// result    result_valid/result_ready   result_item (half_span, bucket_index, last_bucket)
// cfg       cfg_valid/cfg_ready         cfg_index, cfg_data
//
// one sample item per cycle unless a held result stalls the sample side
// min/max update and counters are combinational between input and result registers
// rst is synchronous, restores register defaults and clears counters, no pass done
// a held result stalls the sample side only when the next item also ends a bucket
// cfg writes are taken every cycle
module waveform_peak_envelope_top import wpe_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  output logic                       sample_ready,
  input  sample_item_t               sample_item,
  output logic                       result_valid,
  input  logic                       result_ready,
  output result_item_t               result_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  logic         held_valid;
  sample_item_t held_item;
  logic         step;
  logic         emit;
  logic         free;
  result_item_t core_result;

  assign cfg_ready = 1'b1;
  assign step      = held_valid && (!emit || free);

  wpe_in_reg u_in_reg (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_item  (sample_item),
    .held_valid   (held_valid),
    .held_item    (held_item),
    .pop          (step)
  );

  wpe_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .held_valid (held_valid),
    .held_item  (held_item),
    .step       (step),
    .emit       (emit),
    .result     (core_result)
  );

  wpe_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (step && emit),
    .load_item    (core_result),
    .free         (free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule

@@ verif/testbench.sv @@
module testbench;
  import wpe_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS = 650;
  localparam int QUIET_TAIL = 560;
  localparam int MAX_PASS_ITEMS = 64;
  localparam int REPORT_CAP = 100;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED_FIRST = 3'd4;

  typedef struct packed {
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [CFG_DATA_WIDTH-1:0]  data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_ready;
  sample_item_t sample_item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_item_t result_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

  waveform_peak_envelope_top uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_item  (sample_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // envelope settings and state as the block should hold them
  logic [CHANNEL_COUNT_WIDTH-1:0]    env_channel_count;
  logic [SELECTED_CHANNEL_WIDTH-1:0] env_selected;
  logic [FRAMES_WIDTH-1:0]           env_frames;
  logic [BUCKET_COUNT_WIDTH-1:0]     env_buckets;
  logic [SELECTED_CHANNEL_WIDTH-1:0] env_position;
  logic [FRAMES_WIDTH-1:0]           env_frame;
  logic [BUCKET_INDEX_WIDTH-1:0]     env_bucket;
  logic signed [SAMPLE_WIDTH-1:0]    env_min;
  logic signed [SAMPLE_WIDTH-1:0]    env_max;
  logic                              env_done;

  sample_item_t pending_samples[$];
  reg_write_t cfg_pending[$];
  result_item_t expected_spans[$];

  int samples_queued = 0;
  int samples_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cfg_writes_done = 0;
  int settings_used = 0;
  int random_items = 0;
  int idle_pct = 20;
  int stall_pct = 20;
  int send_gap = 0;
  int stall_gap = 0;
  int quiet_cycles = 0;

  function automatic int clamp_count(int v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_envelope();
    env_position = '0;
    env_frame = '0;
    env_bucket = '0;
    env_min = SAMPLE_MOST_POS;
    env_max = SAMPLE_MOST_NEG;
    env_done = 1'b0;
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MOST_POS;
      1: return SAMPLE_MOST_NEG;
      2: return '0;
      3: return SAMPLE_WIDTH'($urandom_range(0, 3)) - SAMPLE_WIDTH'(2);
      default: return SAMPLE_WIDTH'($urandom());
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_CAP) $display("mismatch: %s", msg);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] value);
    int w;
    int target;
    reg_write_t wr;
    case (idx)
      CFG_CHANNEL_COUNT:    w = CHANNEL_COUNT_WIDTH;
      CFG_SELECTED_CHANNEL: w = SELECTED_CHANNEL_WIDTH;
      CFG_BUCKET_COUNT:     w = BUCKET_COUNT_WIDTH;
      default:              w = CFG_DATA_WIDTH;
    endcase
    // bits above the register width should be dropped
    if (w < CFG_DATA_WIDTH && $urandom_range(0, 3) == 0)
      value = value | (CFG_DATA_WIDTH'($urandom()) << w);
    wr.index = idx;
    wr.data = value;
    target = cfg_writes_done + cfg_pending.size() + 1;
    cfg_pending.push_back(wr);
    while (cfg_writes_done < target) @(posedge clk);
  endtask

  task automatic program_envelope(input int channels, input int sel,
                                  input int frames, input int buckets);
    write_reg(CFG_CHANNEL_COUNT, CFG_DATA_WIDTH'(channels));
    write_reg(CFG_SELECTED_CHANNEL, CFG_DATA_WIDTH'(sel));
    write_reg(CFG_FRAMES_PER_BUCKET, CFG_DATA_WIDTH'(frames));
    write_reg(CFG_BUCKET_COUNT, CFG_DATA_WIDTH'(buckets));
    settings_used++;
  endtask

  task automatic push_sample(input logic [SAMPLE_WIDTH-1:0] s, input logic sop);
    sample_item_t it;
    it.sample = s;
    it.start_of_pass = sop;
    pending_samples.push_back(it);
    samples_queued++;
  endtask

  task automatic settle();
    while (samples_taken < samples_queued || expected_spans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin : cfg_driver
    reg_write_t w;
    if (rst) begin
      cfg_valid <= 1'b0;
      env_channel_count = CHANNEL_COUNT_WIDTH'(1);
      env_selected = '0;
      env_frames = FRAMES_WIDTH'(1);
      env_buckets = BUCKET_COUNT_WIDTH'(1);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CHANNEL_COUNT:     env_channel_count = cfg_data[CHANNEL_COUNT_WIDTH-1:0];
          CFG_SELECTED_CHANNEL:  env_selected = cfg_data[SELECTED_CHANNEL_WIDTH-1:0];
          CFG_FRAMES_PER_BUCKET: env_frames = cfg_data[FRAMES_WIDTH-1:0];
          CFG_BUCKET_COUNT:      env_buckets = cfg_data[BUCKET_COUNT_WIDTH-1:0];
          default: ;
        endcase
        cfg_writes_done++;
      end
      if (!cfg_valid || cfg_ready) begin
        if (cfg_pending.size() != 0) begin
          w = cfg_pending.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= w.index;
          cfg_data <= w.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : sample_driver
    int cc;
    int fpb;
    int nb;
    logic chan_ok;
    logic last;
    logic [HALF_WIDTH-1:0] half;
    result_item_t due;
    if (rst) begin
      sample_valid <= 1'b0;
      send_gap = 0;
      restart_envelope();
    end else begin
      if (sample_valid && sample_ready) begin
        samples_taken++;
        cc = clamp_count(env_channel_count, CHANNELS_MAX);
        fpb = clamp_count(env_frames, FRAMES_PER_BUCKET_MAX);
        nb = clamp_count(env_buckets, BUCKETS_MAX);
        chan_ok = env_selected < cc;
        if (sample_item.start_of_pass) restart_envelope();
        if (!env_done) begin
          if (chan_ok && env_position == env_selected) begin
            if (sample_item.sample < env_min) env_min = sample_item.sample;
            if (sample_item.sample > env_max) env_max = sample_item.sample;
          end
          if (env_position + 1 < cc) begin
            env_position++;
          end else begin
            env_position = '0;
            if (env_frame + 1 < fpb) begin
              env_frame++;
            end else begin
              env_frame = '0;
              half = '0;
              if (chan_ok && env_max >= env_min)
                half = HALF_WIDTH'((int'(env_max) - int'(env_min)) >>> 1);
              last = (int'(env_bucket) + 1 >= nb);
              due.half_span = half;
              due.bucket_index = env_bucket;
              due.last_bucket = last;
              expected_spans.push_back(due);
              env_min = SAMPLE_MOST_POS;
              env_max = SAMPLE_MOST_NEG;
              if (last) env_done = 1'b1;
              else env_bucket++;
            end
          end
        end
      end
      if (!sample_valid || sample_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          sample_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          sample_item <= pending_samples.pop_front();
          sample_valid <= 1'b1;
          if ($urandom_range(0, 99) < idle_pct) send_gap = $urandom_range(1, 7);
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    result_item_t want;
    if (rst) begin
      result_ready <= 1'b0;
      stall_gap = 0;
    end else begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (expected_spans.size() == 0) begin
          report_mismatch($sformatf("result with no item pending: half_span %0d bucket %0d last %0d",
                                    result_item.half_span, result_item.bucket_index,
                                    result_item.last_bucket));
        end else begin
          want = expected_spans.pop_front();
          if (result_item.half_span !== want.half_span)
            report_mismatch($sformatf("bucket %0d half_span %0d, expected %0d", want.bucket_index,
                                      result_item.half_span, want.half_span));
          if (result_item.bucket_index !== want.bucket_index)
            report_mismatch($sformatf("bucket_index %0d, expected %0d",
                                      result_item.bucket_index, want.bucket_index));
          if (result_item.last_bucket !== want.last_bucket)
            report_mismatch($sformatf("bucket %0d last_bucket %0d, expected %0d",
                                      want.bucket_index, result_item.last_bucket,
                                      want.last_bucket));
        end
      end
      if (stall_gap > 0) begin
        stall_gap--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_gap = $urandom_range(1, 7);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("no handshake for %0d cycles, %0d results still due", WATCHDOG_LIMIT,
             expected_spans.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int cc_val;
    int sel_val;
    int fpb_val;
    int nb_val;
    int cc_eff;
    longint pass_items;
    int len;
    int passes;
    logic sop;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, then a sample after the pass is done
    push_sample(SAMPLE_MOST_POS, 1'b1);
    push_sample(SAMPLE_MOST_NEG, 1'b0);
    settle();

    // full-scale span
    program_envelope(1, 0, 2, 2);
    push_sample(SAMPLE_MOST_POS, 1'b1);
    push_sample(SAMPLE_MOST_NEG, 1'b0);
    push_sample(SAMPLE_MOST_NEG, 1'b0);
    push_sample(SAMPLE_MOST_NEG, 1'b0);
    push_sample(random_sample(), 1'b0);
    settle();

    // selected channel out of range
    program_envelope(2, 3, 1, 2);
    for (int k = 0; k < 4; k++) push_sample(random_sample(), k == 0);
    settle();

    // zero registers act as one
    program_envelope(0, 0, 0, 0);
    push_sample(-SAMPLE_WIDTH'(5), 1'b1);
    settle();

    // oversized channel count, unused register index
    write_reg(CFG_UNUSED_FIRST + CFG_INDEX_WIDTH'($urandom_range(0, 3)),
              CFG_DATA_WIDTH'($urandom()));
    program_envelope(15, 7, 1, 1);
    for (int k = 0; k < 8; k++) push_sample(k == 7 ? SAMPLE_MOST_NEG : random_sample(), k == 0);
    settle();

    // registers shrunk in mid pass
    program_envelope(1, 0, 16'hFFFF, 13'h1FFF);
    for (int k = 0; k < 4; k++) push_sample(random_sample(), k == 0);
    settle();
    write_reg(CFG_FRAMES_PER_BUCKET, CFG_DATA_WIDTH'(1));
    push_sample(random_sample(), 1'b0);
    push_sample(random_sample(), 1'b0);
    settle();
    write_reg(CFG_BUCKET_COUNT, CFG_DATA_WIDTH'(1));
    push_sample(random_sample(), 1'b0);
    push_sample(random_sample(), 1'b0);
    settle();

    // bucket that ends without a kept sample
    program_envelope(2, 1, 1, 4);
    push_sample(random_sample(), 1'b1);
    settle();
    write_reg(CFG_SELECTED_CHANNEL, CFG_DATA_WIDTH'(0));
    for (int k = 0; k < 3; k++) push_sample(random_sample(), 1'b0);
    settle();

    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= QUIET_TAIL) begin
        idle_pct = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 35;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      case ($urandom_range(0, 9))
        0: cc_val = 0;
        1: cc_val = $urandom_range(9, 15);
        default: cc_val = $urandom_range(1, 8);
      endcase
      cc_eff = clamp_count(cc_val, CHANNELS_MAX);
      if ($urandom_range(0, 3) == 0) sel_val = $urandom_range(0, 7);
      else sel_val = $urandom_range(0, cc_eff - 1);
      case ($urandom_range(0, 9))
        0: fpb_val = 0;
        1: fpb_val = 65535;
        2: fpb_val = $urandom_range(5, 65534);
        default: fpb_val = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 9))
        0: nb_val = 0;
        1: nb_val = 4096;
        2: nb_val = $urandom_range(4097, 8191);
        3: nb_val = $urandom_range(7, 4095);
        default: nb_val = $urandom_range(1, 6);
      endcase
      if ($urandom_range(0, 7) == 0)
        write_reg(CFG_UNUSED_FIRST + CFG_INDEX_WIDTH'($urandom_range(0, 3)),
                  CFG_DATA_WIDTH'($urandom()));
      program_envelope(cc_val, sel_val, fpb_val, nb_val);
      pass_items = longint'(cc_eff) * clamp_count(fpb_val, FRAMES_PER_BUCKET_MAX) *
                   clamp_count(nb_val, BUCKETS_MAX);
      passes = $urandom_range(1, 3);
      for (int p = 0; p < passes; p++) begin
        if (pass_items <= MAX_PASS_ITEMS) len = int'(pass_items);
        else len = $urandom_range(1, MAX_PASS_ITEMS);
        if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len);
        for (int k = 0; k < len; k++) begin
          // a phase may carry on the pass left open by the last one
          if (k == 0) sop = (p > 0) || ($urandom_range(0, 4) != 0);
          else sop = ($urandom_range(0, 49) == 0);
          push_sample(random_sample(), sop);
          random_items++;
        end
        repeat ($urandom_range(0, 2)) push_sample(random_sample(), 1'b0);
      end
      settle();
    end

    $display("%0d samples taken (%0d random), %0d bucket results checked",
             samples_taken, random_items, results_seen);
    $display("%0d register writes over %0d envelope settings", cfg_writes_done, settings_used);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
